// ----- sv/udpcs_pkg.sv -----
// ----------------------------------------------------------------------------
// udpcs_pkg
// Types and constants shared by the UDP-over-IPv6 checksum stream blocks.
// ----------------------------------------------------------------------------
package udpcs_pkg;

  // Kind of input item
  typedef enum logic {
    OP_ADDR = 1'b0,   // one source and one destination address word
    OP_DATA = 1'b1    // one UDP header or payload byte
  } op_e;

  localparam int unsigned WordBits = 16;
  localparam int unsigned ByteBits = 8;

  // Protocol number added to the pseudo-header sum
  localparam logic [WordBits-1:0] UdpProtocol = 16'd17;
  localparam logic [WordBits-1:0] WordMax     = 16'hffff;

  // Input item
  typedef struct packed {
    op_e                 operation;
    logic [WordBits-1:0] src_word;
    logic [WordBits-1:0] dst_word;
    logic [ByteBits-1:0] data_byte;
    logic                last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [WordBits-1:0] checksum;
    logic                length_overflow;
  } out_item_t;

  // Registered input item handed to the sum core
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_slot_t;

  // Result produced by the sum core for the output register
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } res_slot_t;

  // Fold an 18-bit sum of four words into 16 bits with end-around carry
  function automatic logic [WordBits-1:0] fold18(input logic [WordBits+1:0] s);
    logic [WordBits:0] t;
    logic [WordBits:0] u;
    t = {1'b0, s[WordBits-1:0]} + {{(WordBits-1){1'b0}}, s[WordBits+1:WordBits]};
    u = {1'b0, t[WordBits-1:0]} + {{WordBits{1'b0}}, t[WordBits]};
    return u[WordBits-1:0];
  endfunction

endpackage

// ----- sv/udpcs_in_stage.sv -----
// ----------------------------------------------------------------------------
// udpcs_in_stage
// Input register: holds one accepted item until the sum core consumes it.
// ----------------------------------------------------------------------------
module udpcs_in_stage import udpcs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  input  logic     take_i,     // core consumes the held item this cycle
  output in_slot_t slot_o
);

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  // Stall only while a held item cannot move on
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_data_i;
    end
  end

  assign slot_o.valid = valid_q;
  assign slot_o.item  = item_q;

endmodule

// ----- sv/udpcs_core.sv -----
// ----------------------------------------------------------------------------
// udpcs_core
// Running ones-complement sum, byte count and pairing of data bytes.
// ----------------------------------------------------------------------------
module udpcs_core import udpcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_slot_t  slot_i,
  input  logic      out_free_i,  // output register can load this cycle
  output logic      take_o,
  output res_slot_t res_o
);

  logic [WordBits-1:0] sum_q, sum_d;
  logic [WordBits-1:0] count_q, count_d;
  logic [ByteBits-1:0] held_q, held_d;
  logic                ovf_q, ovf_d;

  logic                is_data, is_final, odd_pos, ovf_new;
  logic [WordBits-1:0] count_inc;
  logic [WordBits-1:0] op_b, op_c, op_d;
  logic [WordBits+1:0] wide_sum;
  logic [WordBits-1:0] folded;

  assign is_data  = (slot_i.item.operation == OP_DATA);
  assign is_final = is_data && slot_i.item.last;
  assign odd_pos  = count_q[0];

  // A final byte needs room in the output register; others always go
  assign take_o = slot_i.valid && (!is_final || out_free_i);

  assign count_inc = count_q + 16'd1;
  assign ovf_new   = ovf_q || (count_q == WordMax);

  // Operand selection for the single four-input sum
  always_comb begin
    op_b = '0;
    op_c = '0;
    op_d = '0;
    if (!is_data) begin
      op_b = slot_i.item.src_word;
      op_c = slot_i.item.dst_word;
    end else begin
      if (odd_pos) begin
        op_b = {held_q, slot_i.item.data_byte};
      end else if (slot_i.item.last) begin
        // trailing odd byte, zero padded
        op_b = {slot_i.item.data_byte, {ByteBits{1'b0}}};
      end
      if (slot_i.item.last) begin
        op_c = count_inc;
        op_d = UdpProtocol;
      end
    end
  end

  assign wide_sum = {2'b00, sum_q} + {2'b00, op_b} + {2'b00, op_c} + {2'b00, op_d};
  assign folded   = fold18(wide_sum);

  // State update
  always_comb begin
    sum_d   = sum_q;
    count_d = count_q;
    held_d  = held_q;
    ovf_d   = ovf_q;
    if (take_o) begin
      if (is_final) begin
        sum_d   = '0;
        count_d = '0;
        held_d  = '0;
        ovf_d   = 1'b0;
      end else if (is_data) begin
        sum_d   = folded;
        count_d = count_inc;
        ovf_d   = ovf_new;
        if (!odd_pos) begin
          held_d = slot_i.item.data_byte;
        end
      end else begin
        sum_d = folded;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      count_q <= '0;
      held_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      sum_q   <= sum_d;
      count_q <= count_d;
      held_q  <= held_d;
      ovf_q   <= ovf_d;
    end
  end

  assign res_o.valid                = take_o && is_final;
  assign res_o.item.checksum        = ~folded;
  assign res_o.item.length_overflow = ovf_new;

endmodule

// ----- sv/udpcs_out_stage.sv -----
// ----------------------------------------------------------------------------
// udpcs_out_stage
// Output register: holds one finished checksum until it is transferred.
// ----------------------------------------------------------------------------
module udpcs_out_stage import udpcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_slot_t res_i,
  output logic      free_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      valid_q, valid_d;
  out_item_t item_q;

  // Free when empty or when the held result transfers this cycle
  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (res_i.valid) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_i.valid) begin
      item_q <= res_i.item;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = item_q;

endmodule

// ----- sv/udp_ipv6_checksum_stream.sv -----
// ----------------------------------------------------------------------------
// udp_ipv6_checksum_stream
// UDP checksum over an IPv6 pseudo-header, one address pair or byte per item.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i / in_stall_o  in_item_t  (address pair or byte)
//  out       output     out_valid_o/ out_stall_i out_item_t (checksum, overflow)
//
//  One item per clock is accepted while in_stall_o is low; each item is held in
//  the input register and then summed by one four-input 18-bit add and fold.
//  A final byte's checksum passes the input and output registers to reach out.
//  Reset clears the sum, byte count, held byte and all valid flags.
//  Input stalls only while a final byte waits behind a stalled result.
// ----------------------------------------------------------------------------
module udp_ipv6_checksum_stream import udpcs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  in_slot_t  slot;
  res_slot_t res;
  logic      take;
  logic      out_free;

  udpcs_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .take_i     (take),
    .slot_o     (slot)
  );

  udpcs_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .slot_i     (slot),
    .out_free_i (out_free),
    .take_o     (take),
    .res_o      (res)
  );

  udpcs_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A result is only produced from a held final data byte
  a_res_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid |-> (slot.valid && slot.item.operation == OP_DATA && slot.item.last))
    else $error("result without a final data byte");

  // Input backpressure only comes from a blocked output register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  // A new result shows up only after the core produced one
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(res.valid))
    else $error("output valid without a produced result");

endmodule
